// ----- design/pirgb_pkg.sv -----
// Shared constants for the palette index to RGB pixel expander.
// No dependencies; imported by pirgb_chan and palette_index_to_rgb_pixel.
package pirgb_pkg;

   // Palette geometry
   localparam int PIRGB_DEPTH   = 256;
   localparam int PIRGB_ENTRY_W = 24;
   localparam int CHAN_W        = 8;
   localparam int PIXEL_W       = 32;
   localparam int SHIFT_W       = 5;
   localparam int PROD_W        = 2 * CHAN_W;

   // Dimming applies to entries at and above this number
   localparam logic [8:0] DIM_FIRST_ENTRY = 9'd16;

   // Input opcodes
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   // Destination depth codes
   localparam logic [1:0] DEPTH_8  = 2'd0;
   localparam logic [1:0] DEPTH_16 = 2'd1;
   localparam logic [1:0] DEPTH_32 = 2'd2;

   // CSR register indexes (byte address = 4 * index)
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_RED_MAX     = 3'd0;
   localparam logic [2:0] REG_GREEN_MAX   = 3'd1;
   localparam logic [2:0] REG_BLUE_MAX    = 3'd2;
   localparam logic [2:0] REG_RED_SHIFT   = 3'd3;
   localparam logic [2:0] REG_GREEN_SHIFT = 3'd4;
   localparam logic [2:0] REG_BLUE_SHIFT  = 3'd5;
   localparam logic [2:0] REG_DEPTH_MODE  = 3'd6;
   localparam logic [2:0] REG_PARTIAL_DIM = 3'd7;

   // Pipeline advance control handed to the channel units
   typedef struct packed {
      logic advance;
   } pipe_ctl_type;

endpackage

// ----- design/pirgb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pirgb_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/pirgb_chan.sv -----
// One color channel: optional dim by four, scale by max, divide by 255.
// Two register stages (product, quotient). Depends on pirgb_pkg.
module pirgb_chan (
   input  logic                       clock,
   input  pirgb_pkg::pipe_ctl_type    ctl,
   input  logic [pirgb_pkg::CHAN_W-1:0] chan_byte,
   input  logic                       dim,
   input  logic [pirgb_pkg::CHAN_W-1:0] chan_max,
   output logic [pirgb_pkg::CHAN_W-1:0] chan_q
);
   import pirgb_pkg::*;

   logic [CHAN_W-1:0] dimmed;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic [PROD_W-1:0] qsum;
   logic [CHAN_W-1:0] q_in, q_ff;

   always_comb begin
      dimmed  = dim ? {2'b00, chan_byte[CHAN_W-1:2]} : chan_byte;
      prod_in = dimmed * chan_max;
      // floor(p / 255) for p <= 255*255: (p + p/256 + 1) / 256
      qsum    = prod_ff + {{CHAN_W{1'b0}}, prod_ff[PROD_W-1:CHAN_W]} + PROD_W'(1);
      q_in    = qsum[PROD_W-1:CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_ff <= prod_in;
         q_ff    <= q_in;
      end
   end

   assign chan_q = q_ff;

endmodule

// ----- design/palette_index_to_rgb_pixel.sv -----
// Top level of the palette index to RGB pixel expander.
// Depends on pirgb_pkg, pirgb_ram and pirgb_chan.
//
// Each req_ transfer either writes one palette entry (opcode 0, no result)
// or converts one 8-bit pixel index (opcode 1, one rsp_ transfer). The
// block takes one transfer per clock. It has four register stages: palette
// RAM read, dim and multiply by the channel max, divide by 255, then
// shift/OR/mask into the output register. The valid flag of a conversion
// runs through s1_valid_ff, s2_valid_ff and s3_valid_ff to rsp_valid_ff. All
// stages move together; a stall on rsp_ready holds every stage and drops
// req_ready in the same cycle, so throughput is one pixel per clock whenever
// the sink takes it. A write updates the RAM at its acceptance edge, so a
// conversion of the same entry may follow in the very next cycle.
// Converting an entry never written since reset returns an undefined pixel
// unless the depth is 8-bit. Indexes are reduced modulo PALETTE_DEPTH. CSRs
// (APB, byte address 4*index) may only be changed while the pipe is empty.
module palette_index_to_rgb_pixel #(
   parameter int PALETTE_DEPTH = pirgb_pkg::PIRGB_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [7:0]                        req_color_index,
   input  logic [pirgb_pkg::CHAN_W-1:0]      req_red_in,
   input  logic [pirgb_pkg::CHAN_W-1:0]      req_green_in,
   input  logic [pirgb_pkg::CHAN_W-1:0]      req_blue_in,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pirgb_pkg::PIXEL_W-1:0]     rsp_pixel_out,
   // CSR port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pirgb_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import pirgb_pkg::*;

   localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   // index -> entry map (index mod depth), built at elaboration
   typedef logic [ADDR_W-1:0] entry_map_type [256];

   function automatic entry_map_type build_entry_map();
      entry_map_type    m;
      logic [ADDR_W-1:0] r;
      r = '0;
      for (int i = 0; i < 256; i++) begin
         m[i] = r;
         r = (r == ADDR_W'(PALETTE_DEPTH - 1)) ? '0 : r + ADDR_W'(1);
      end
      return m;
   endfunction

   localparam entry_map_type ENTRY_MAP = build_entry_map();

   // ---------------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------------
   logic [CHAN_W-1:0]  red_max_ff, green_max_ff, blue_max_ff;
   logic [SHIFT_W-1:0] red_shift_ff, green_shift_ff, blue_shift_ff;
   logic [1:0]         depth_mode_ff;
   logic               partial_dim_ff;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_max_ff     <= 8'd255;
         green_max_ff   <= 8'd255;
         blue_max_ff    <= 8'd255;
         red_shift_ff   <= 5'd16;
         green_shift_ff <= 5'd8;
         blue_shift_ff  <= 5'd0;
         depth_mode_ff  <= DEPTH_32;
         partial_dim_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_RED_MAX:     red_max_ff     <= pwdata[CHAN_W-1:0];
            REG_GREEN_MAX:   green_max_ff   <= pwdata[CHAN_W-1:0];
            REG_BLUE_MAX:    blue_max_ff    <= pwdata[CHAN_W-1:0];
            REG_RED_SHIFT:   red_shift_ff   <= pwdata[SHIFT_W-1:0];
            REG_GREEN_SHIFT: green_shift_ff <= pwdata[SHIFT_W-1:0];
            REG_BLUE_SHIFT:  blue_shift_ff  <= pwdata[SHIFT_W-1:0];
            REG_DEPTH_MODE:  depth_mode_ff  <= pwdata[1:0];
            REG_PARTIAL_DIM: partial_dim_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_RED_MAX:     prdata = {24'b0, red_max_ff};
         REG_GREEN_MAX:   prdata = {24'b0, green_max_ff};
         REG_BLUE_MAX:    prdata = {24'b0, blue_max_ff};
         REG_RED_SHIFT:   prdata = {27'b0, red_shift_ff};
         REG_GREEN_SHIFT: prdata = {27'b0, green_shift_ff};
         REG_BLUE_SHIFT:  prdata = {27'b0, blue_shift_ff};
         REG_DEPTH_MODE:  prdata = {30'b0, depth_mode_ff};
         REG_PARTIAL_DIM: prdata = {31'b0, partial_dim_ff};
         default:         prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage advances when the output register is
   // free or being drained.
   // ---------------------------------------------------------------------
   pipe_ctl_type ctl;
   logic         req_xfer;
   logic         conv_xfer;
   logic         wr_xfer;
   logic [ADDR_W-1:0] entry;
   logic         dim_in;

   assign ctl.advance = ~rsp_valid | rsp_ready;
   assign req_ready   = ctl.advance;
   assign req_xfer    = req_valid & req_ready;
   assign conv_xfer   = req_xfer & (req_opcode == OP_CONVERT);
   assign wr_xfer     = req_xfer & (req_opcode == OP_WRITE);
   assign entry       = ENTRY_MAP[req_color_index];
   assign dim_in      = partial_dim_ff & ({{(9 - ADDR_W){1'b0}}, entry} >= DIM_FIRST_ENTRY);

   // Stage 1: palette read
   logic [PIRGB_ENTRY_W-1:0] pal_word;

   pirgb_ram #(
      .DATA_W (PIRGB_ENTRY_W),
      .DEPTH  (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_xfer),
      .wr_addr (entry),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_en   (ctl.advance),
      .rd_addr (entry),
      .rd_data (pal_word)
   );

   // valid/index/dim travel alongside the data
   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [7:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic       s1_dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         s1_valid_ff <= conv_xfer;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         s1_idx_ff <= req_color_index;
         s1_dim_ff <= dim_in;
         s2_idx_ff <= s1_idx_ff;
         s3_idx_ff <= s2_idx_ff;
      end
   end

   // Stages 2 and 3: scale and divide, one unit per channel
   logic [CHAN_W-1:0] red_q, green_q, blue_q;

   pirgb_chan u_red (
      .clock     (clock),
      .ctl       (ctl),
      .chan_byte (pal_word[23:16]),
      .dim       (s1_dim_ff),
      .chan_max  (red_max_ff),
      .chan_q    (red_q)
   );

   pirgb_chan u_green (
      .clock     (clock),
      .ctl       (ctl),
      .chan_byte (pal_word[15:8]),
      .dim       (s1_dim_ff),
      .chan_max  (green_max_ff),
      .chan_q    (green_q)
   );

   pirgb_chan u_blue (
      .clock     (clock),
      .ctl       (ctl),
      .chan_byte (pal_word[7:0]),
      .dim       (s1_dim_ff),
      .chan_max  (blue_max_ff),
      .chan_q    (blue_q)
   );

   // Stage 4: pack into output register
   logic [PIXEL_W-1:0] packed_pix;
   logic [PIXEL_W-1:0] pixel_in, pixel_ff;
   logic               rsp_valid_ff;

   always_comb begin
      // bits shifted past bit 31 fall off
      packed_pix = (PIXEL_W'(red_q) << red_shift_ff)
                 | (PIXEL_W'(green_q) << green_shift_ff)
                 | (PIXEL_W'(blue_q) << blue_shift_ff);
      case (depth_mode_ff)
         DEPTH_8:  pixel_in = PIXEL_W'(s3_idx_ff);
         DEPTH_32: pixel_in = packed_pix;
         default:  pixel_in = {16'b0, packed_pix[15:0]};  // 16-bit and unused code
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = pixel_ff;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for palette_index_to_rgb_pixel.
// Depends on pirgb_pkg and the palette_index_to_rgb_pixel RTL; no files or plusargs.
module tb;
   import pirgb_pkg::*;

   localparam int PAL_DEPTH      = PIRGB_DEPTH;
   localparam int N_PHASES       = 11;
   localparam int RAND_PER_PHASE = 48;
   localparam int SETTLE_CYCLES  = 8;     // pipe is four deep; margin on top
   localparam int QUIET_LIMIT    = 2000;  // idle cycles before the run is declared hung

   // Destination pixel format as held in the CSRs
   typedef struct packed {
      logic [7:0] red_max;
      logic [7:0] green_max;
      logic [7:0] blue_max;
      logic [4:0] red_shift;
      logic [4:0] green_shift;
      logic [4:0] blue_shift;
      logic [1:0] depth;
      logic       dim;
   } pixel_fmt_type;

   // One request transfer
   typedef struct packed {
      logic       opcode;
      logic [7:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } palette_req_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode      = OP_WRITE;
   logic [7:0]  req_color_index = '0;
   logic [7:0]  req_red_in      = '0;
   logic [7:0]  req_green_in    = '0;
   logic [7:0]  req_blue_in     = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   palette_index_to_rgb_pixel dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_color_index (req_color_index),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // Shadow state: CSRs as last written, and the palette as seen by accepted writes
   pixel_fmt_type fmt_shadow = '{8'd255, 8'd255, 8'd255, 5'd16, 5'd8, 5'd0, DEPTH_32, 1'b0};
   logic [23:0]  pal_shadow [PAL_DEPTH];

   palette_req_type req_backlog [$];   // items not yet put on the bus
   logic [31:0]  pixel_due [$];     // predicted pixels, oldest first
   logic [7:0]   written_list [$];  // entries that hold a defined color
   bit           written_map [256];

   bit  burst_mode  = 1'b0;  // no gaps on either side while set
   bit  req_took    = 1'b0;  // request transfer seen at the last rising edge
   int  send_gap    = 0;
   int  sink_stall  = 0;
   int  quiet_cycles = 0;
   int  mismatches  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_max();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 8'd0;
      if (r < 35) return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   // One channel: optional quarter dimming, scale to max/255, place at its shift.
   // Bits pushed past bit 31 fall off.
   function automatic logic [31:0] scale_channel(input logic [7:0] level, input logic dim,
                                                 input logic [7:0] maxv, input logic [4:0] sh);
      logic [7:0]  v;
      logic [15:0] prod;
      logic [31:0] w;
      v    = dim ? level / 8'd4 : level;
      prod = v * maxv;
      w    = 32'(prod / 16'd255);
      return w << sh;
   endfunction

   function automatic logic [31:0] predict_pixel(input logic [7:0] color_index);
      int          entry;
      logic [23:0] word;
      logic        dim;
      logic [31:0] pix;
      entry = int'(color_index) % PAL_DEPTH;
      // 8-bit destination passes the raw index through, unreduced
      if (fmt_shadow.depth == DEPTH_8) return {24'd0, color_index};
      word = pal_shadow[entry];
      dim  = fmt_shadow.dim && (entry >= int'(DIM_FIRST_ENTRY));
      pix  = scale_channel(word[23:16], dim, fmt_shadow.red_max, fmt_shadow.red_shift)
           | scale_channel(word[15:8], dim, fmt_shadow.green_max, fmt_shadow.green_shift)
           | scale_channel(word[7:0], dim, fmt_shadow.blue_max, fmt_shadow.blue_shift);
      // 16-bit mode and the spare depth code both keep the low half only
      if (fmt_shadow.depth != DEPTH_32) pix[31:16] = '0;
      return pix;
   endfunction

   function automatic void push_write(input logic [7:0] idx, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b);
      req_backlog.push_back('{OP_WRITE, idx, r, g, b});
      if (!written_map[idx]) begin
         written_map[idx] = 1'b1;
         written_list.push_back(idx);
      end
   endfunction

   // Color bytes are don't-care on a convert; random keeps their bits moving
   function automatic void push_convert(input logic [7:0] idx);
      req_backlog.push_back('{OP_CONVERT, idx, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))});
   endfunction

   // APB write: setup cycle, then access cycle; shadow follows once pready completes it
   task automatic csr_write(input logic [2:0] reg_idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (reg_idx)
         REG_RED_MAX:     fmt_shadow.red_max     = value[7:0];
         REG_GREEN_MAX:   fmt_shadow.green_max   = value[7:0];
         REG_BLUE_MAX:    fmt_shadow.blue_max    = value[7:0];
         REG_RED_SHIFT:   fmt_shadow.red_shift   = value[4:0];
         REG_GREEN_SHIFT: fmt_shadow.green_shift = value[4:0];
         REG_BLUE_SHIFT:  fmt_shadow.blue_shift  = value[4:0];
         REG_DEPTH_MODE:  fmt_shadow.depth       = value[1:0];
         REG_PARTIAL_DIM: fmt_shadow.dim         = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Hold off until the backlog is on the bus, every pixel is back, and the
   // pipe has had time to flush any trailing palette write.
   task automatic wait_idle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_valid || pixel_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: valid holds with a stable payload until the transfer
   always @(negedge clock) begin
      palette_req_type cur;
      logic         next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         next_valid = req_valid && !req_took;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (req_backlog.size() > 0) begin
               cur = req_backlog.pop_front();
               req_opcode      <= cur.opcode;
               req_color_index <= cur.color_index;
               req_red_in      <= cur.red;
               req_green_in    <= cur.green;
               req_blue_in     <= cur.blue;
               next_valid = 1'b1;
               if (!burst_mode && $urandom_range(0, 99) < 30) send_gap = idle_len();
            end
         end
         req_valid <= next_valid;
      end
   end

   // Result sink: random back-pressure on rsp_ready
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         sink_stall = 0;
      end else if (sink_stall > 0) begin
         rsp_ready <= 1'b0;
         sink_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (!burst_mode && $urandom_range(0, 99) < 25) sink_stall = idle_len();
      end
   end

   // Monitor: predicts on each request transfer, checks each result transfer,
   // and watches for a hung pipe.
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         req_took     <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_took <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            if (req_opcode == OP_WRITE)
               pal_shadow[int'(req_color_index) % PAL_DEPTH] =
                  {req_red_in, req_green_in, req_blue_in};
            else
               pixel_due.push_back(predict_pixel(req_color_index));
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_due.size() == 0) begin
               $error("pixel_out: no transfer expected, got %h", rsp_pixel_out);
               mismatches++;
            end else begin
               want = pixel_due.pop_front();
               if (rsp_pixel_out !== want) begin
                  $error("pixel_out: expected %h, got %h", want, rsp_pixel_out);
                  mismatches++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Stimulus: one phase per pixel format. Phase 0 runs on reset values, the
   // next few pin the corner formats, the rest are random.
   initial begin
      pixel_fmt_type next_fmt;
      logic [7:0] idx;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < N_PHASES; ph++) begin
         if (ph > 0) begin
            case (ph)
               // shifts near the top: channel bits run off bit 31; dimming on
               1: next_fmt = '{8'd255, 8'd255, 8'd255, 5'd31, 5'd24, 5'd28, DEPTH_32, 1'b1};
               // zero max: every channel scales to nothing
               2: next_fmt = '{8'd0, 8'd0, 8'd0, 5'd0, 5'd0, 5'd0, DEPTH_16, 1'b1};
               // 8-bit destination passes the index straight through
               3: next_fmt = '{8'd1, 8'd128, 8'd254, 5'd0, 5'd5, 5'd10, DEPTH_8, 1'b0};
               // spare depth code acts as 16-bit
               4: next_fmt = '{8'd200, 8'd77, 8'd255, 5'd11, 5'd5, 5'd0, 2'd3, 1'b1};
               // classic 5-6-5
               5: next_fmt = '{8'd31, 8'd63, 8'd31, 5'd11, 5'd5, 5'd0, DEPTH_16, 1'b0};
               default: begin
                  next_fmt.red_max     = pick_max();
                  next_fmt.green_max   = pick_max();
                  next_fmt.blue_max    = pick_max();
                  next_fmt.red_shift   = 5'($urandom_range(0, 31));
                  next_fmt.green_shift = 5'($urandom_range(0, 31));
                  next_fmt.blue_shift  = 5'($urandom_range(0, 31));
                  next_fmt.depth       = 2'($urandom_range(0, 3));
                  next_fmt.dim         = 1'($urandom_range(0, 1));
               end
            endcase
            csr_write(REG_RED_MAX,     32'(next_fmt.red_max));
            csr_write(REG_GREEN_MAX,   32'(next_fmt.green_max));
            csr_write(REG_BLUE_MAX,    32'(next_fmt.blue_max));
            csr_write(REG_RED_SHIFT,   32'(next_fmt.red_shift));
            csr_write(REG_GREEN_SHIFT, 32'(next_fmt.green_shift));
            csr_write(REG_BLUE_SHIFT,  32'(next_fmt.blue_shift));
            csr_write(REG_DEPTH_MODE,  32'(next_fmt.depth));
            csr_write(REG_PARTIAL_DIM, 32'(next_fmt.dim));
         end

         burst_mode = (ph == 2) || ($urandom_range(0, 3) == 0);

         // Directed items for the corner formats
         case (ph)
            0: begin
               push_write(8'd0,   8'h00, 8'h00, 8'h00);
               push_write(8'd255, 8'hFF, 8'hFF, 8'hFF);
               push_write(8'd15,  8'hAA, 8'h55, 8'hA5);  // last undimmed entry
               push_write(8'd16,  8'h5A, 8'hC3, 8'h3C);  // first dimmed entry
               push_write(8'd128, 8'h01, 8'h80, 8'hFE);
               push_convert(8'd0);
               push_convert(8'd255);
               push_convert(8'd15);
               push_convert(8'd16);
               push_convert(8'd128);
               // overwrite, then read back on the very next transfer
               push_write(8'd255, 8'h12, 8'h34, 8'h56);
               push_convert(8'd255);
            end
            1: begin
               push_convert(8'd15);
               push_convert(8'd16);
               push_convert(8'd255);
               push_convert(8'd128);
            end
            2: push_convert(8'd255);
            3: begin
               push_convert(8'd255);
               push_convert(8'd0);
            end
            4: begin
               push_convert(8'd255);
               push_convert(8'd16);
            end
            default: ;
         endcase

         // Random mix: writes anywhere, converts only of entries already written
         for (int k = 0; k < RAND_PER_PHASE; k++) begin
            if ($urandom_range(0, 99) < 35 || written_list.size() == 0) begin
               if ($urandom_range(0, 4) == 0)
                  idx = 8'($urandom_range(14, 17));  // around the dimming boundary
               else
                  idx = 8'($urandom_range(0, 255));
               push_write(idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end else begin
               push_convert(written_list[$urandom_range(0, written_list.size() - 1)]);
            end
         end

         // Sender pauses here until the pipe has drained
         wait_idle();
      end

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- palette_index_to_rgb_pixel.f -----
design/pirgb_pkg.sv
design/pirgb_ram.sv
design/pirgb_chan.sv
design/palette_index_to_rgb_pixel.sv
dv/tb.sv
